// ===== rtl/core/window_stationary_detector_macros.svh =====
// Assertion macros for the window stationary detector
`ifndef WINDOW_STATIONARY_DETECTOR_MACROS_SVH
`define WINDOW_STATIONARY_DETECTOR_MACROS_SVH

// Property checked on every clock edge outside reset
`define WSD_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("wsd assertion failed");

// Consequence must hold in the cycle after the antecedent
`define WSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wsd assertion failed");

`endif

// ===== rtl/core/wsd_pkg.sv =====
// Shared types and constants of the window stationary detector
`timescale 1ns / 1ps
package wsd_pkg;

  localparam int unsigned DataW   = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] RegMotionThreshold = 2'd0;
  localparam logic [CfgIdxW-1:0] RegDwellSamples    = 2'd1;

  localparam logic OpSample = 1'b0;
  localparam logic OpClear  = 1'b1;

  localparam logic [DataW-1:0] ThresholdReset = 16'd100;
  localparam logic [DataW-1:0] DwellReset     = 16'd60;
  localparam logic [DataW-1:0] DwellMax       = 16'hFFFF;

  typedef struct packed {
    logic signed [DataW-1:0] x;
    logic signed [DataW-1:0] y;
  } sample_t;

  typedef struct packed {
    logic             settled;
    logic             still;
    logic             window_full;
    logic [DataW-1:0] spread_x;
    logic [DataW-1:0] spread_y;
  } result_t;

  typedef struct packed {
    logic en;
    logic init;
  } scan_ctrl_t;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StScan = 4'b0010,
    StEval = 4'b0100,
    StEmit = 4'b1000
  } state_e;

endpackage

// ===== rtl/core/wsd_intf.sv =====
// Handshake channel interfaces: sample input, result output, register writes
`timescale 1ns / 1ps
interface wsd_in_if;
  logic                            valid;
  logic                            ready;
  logic                            opcode;
  logic signed [wsd_pkg::DataW-1:0] pos_x;
  logic signed [wsd_pkg::DataW-1:0] pos_y;

  modport source (output valid, output opcode, output pos_x, output pos_y, input ready);
  modport sink   (input valid, input opcode, input pos_x, input pos_y, output ready);
endinterface

interface wsd_out_if;
  logic                      valid;
  logic                      ready;
  logic                      settled;
  logic                      still;
  logic                      window_full;
  logic [wsd_pkg::DataW-1:0] spread_x;
  logic [wsd_pkg::DataW-1:0] spread_y;

  modport source (output valid, output settled, output still, output window_full,
                  output spread_x, output spread_y, input ready);
  modport sink   (input valid, input settled, input still, input window_full,
                  input spread_x, input spread_y, output ready);
endinterface

interface wsd_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [wsd_pkg::CfgIdxW-1:0] index;
  logic [wsd_pkg::DataW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/window_stationary_detector.sv =====
// Flow: a sample on a full window is shifted in, then the cell ring rotates once fully past
//   a single min/max comparator per axis (StScan), the spreads are compared (StEval)
//   and the result is emitted (StEmit); a clear or a sample while the window is still filling
//   goes straight to StEmit. A new beat is taken only in StIdle, after the last result is loaded.
// Reset (async, active low): window empty, still and dwell cleared, threshold 100,
//   dwell 60; cell contents are not cleared.
`timescale 1ns / 1ps
`include "window_stationary_detector_macros.svh"
module window_stationary_detector #(
  parameter int unsigned WINDOW = 50
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  wsd_in_if.sink    in_i,
  wsd_out_if.source out_o,
  wsd_cfg_if.sink   cfg_i
);

  localparam int unsigned FillW = $clog2(WINDOW + 1);
  localparam int unsigned CntW  = $clog2(WINDOW);
  localparam logic [FillW-1:0] FillFull = FillW'(WINDOW);
  localparam logic [CntW-1:0]  CntLast  = CntW'(WINDOW - 1);

  wsd_pkg::state_e state_q, state_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             still_q, still_d;
  logic [wsd_pkg::DataW-1:0] dwell_q, dwell_d, dwell_inc;
  logic [wsd_pkg::DataW-1:0] thr_q, dwell_set_q;
  wsd_pkg::result_t res_q, res_d, out_q;
  logic             out_valid_q, out_valid_d, out_load;

  logic             in_acc, cfg_acc, shift;
  wsd_pkg::sample_t new_sample, ring_in;
  wsd_pkg::sample_t cell_out [WINDOW];
  wsd_pkg::scan_ctrl_t scan_ctrl;
  logic [wsd_pkg::DataW-1:0] spread_x, spread_y;

  assign in_i.ready  = (state_q == wsd_pkg::StIdle);
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;

  assign new_sample.x = in_i.pos_x;
  assign new_sample.y = in_i.pos_y;

  // The ring shifts in a new sample on accepting a sample and rotates once fully while scanning
  assign shift   = (in_acc && (in_i.opcode == wsd_pkg::OpSample)) ||
                   (state_q == wsd_pkg::StScan);
  assign ring_in = (state_q == wsd_pkg::StScan) ? cell_out[WINDOW-1] : new_sample;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    if (i == 0) begin : g_head
      wsd_cell u_cell (
        .clk_i    (clk_i),
        .shift_i  (shift),
        .sample_i (ring_in),
        .sample_o (cell_out[i])
      );
    end else begin : g_body
      wsd_cell u_cell (
        .clk_i    (clk_i),
        .shift_i  (shift),
        .sample_i (cell_out[i-1]),
        .sample_o (cell_out[i])
      );
    end
  end

  assign scan_ctrl.en   = (state_q == wsd_pkg::StScan);
  assign scan_ctrl.init = (cnt_q == '0);

  wsd_spread u_spread_x (
    .clk_i    (clk_i),
    .ctrl_i   (scan_ctrl),
    .value_i  (cell_out[WINDOW-1].x),
    .spread_o (spread_x)
  );

  wsd_spread u_spread_y (
    .clk_i    (clk_i),
    .ctrl_i   (scan_ctrl),
    .value_i  (cell_out[WINDOW-1].y),
    .spread_o (spread_y)
  );

  assign dwell_inc = (dwell_q == wsd_pkg::DwellMax) ? dwell_q : dwell_q + 16'd1;
  assign out_load  = (state_q == wsd_pkg::StEmit) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    cnt_d       = cnt_q;
    still_d     = still_q;
    dwell_d     = dwell_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && out_o.ready) out_valid_d = 1'b0;

    case (state_q)
      wsd_pkg::StIdle: begin
        if (in_acc) begin
          res_d = '0;
          if (in_i.opcode == wsd_pkg::OpClear) begin
            fill_d  = '0;
            still_d = 1'b0;
            dwell_d = '0;
            state_d = wsd_pkg::StEmit;
          end else if (fill_q >= FillFull - FillW'(1)) begin
            fill_d  = FillFull;
            cnt_d   = '0;
            state_d = wsd_pkg::StScan;
          end else begin
            fill_d  = fill_q + FillW'(1);
            state_d = wsd_pkg::StEmit;
          end
        end
      end
      wsd_pkg::StScan: begin
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntLast) begin
          state_d = wsd_pkg::StEval;
        end
      end
      wsd_pkg::StEval: begin
        if ((spread_x < thr_q) && (spread_y < thr_q)) begin
          still_d = 1'b1;
          dwell_d = still_q ? dwell_inc : '0;
          res_d.settled = (dwell_d >= dwell_set_q);
        end else begin
          still_d = 1'b0;
          dwell_d = '0;
          res_d.settled = 1'b0;
        end
        res_d.still       = still_d;
        res_d.window_full = 1'b1;
        res_d.spread_x    = spread_x;
        res_d.spread_y    = spread_y;
        state_d           = wsd_pkg::StEmit;
      end
      wsd_pkg::StEmit: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = wsd_pkg::StIdle;
        end
      end
      default: begin
        state_d = wsd_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wsd_pkg::StIdle;
      fill_q      <= '0;
      cnt_q       <= '0;
      still_q     <= 1'b0;
      dwell_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      cnt_q       <= cnt_d;
      still_q     <= still_d;
      dwell_q     <= dwell_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= wsd_pkg::ThresholdReset;
      dwell_set_q <= wsd_pkg::DwellReset;
    end else if (cfg_acc) begin
      case (cfg_i.index)
        wsd_pkg::RegMotionThreshold: thr_q       <= cfg_i.data;
        wsd_pkg::RegDwellSamples:    dwell_set_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.settled     = out_q.settled;
  assign out_o.still       = out_q.still;
  assign out_o.window_full = out_q.window_full;
  assign out_o.spread_x    = out_q.spread_x;
  assign out_o.spread_y    = out_q.spread_y;

  // still can only be held while the window is full
  `WSD_ASSERT(a_still_needs_full, !still_q || (fill_q == FillFull))
  // a full rotation always ends in the evaluation step
  `WSD_ASSERT_NEXT(a_scan_ends, (state_q == wsd_pkg::StScan) && (cnt_q == CntLast),
                   state_q == wsd_pkg::StEval)
  // settled beats imply still on a full window
  `WSD_ASSERT(a_settled_still, !(out_valid_q && out_q.settled) ||
                               (out_q.still && out_q.window_full))
  // nonzero spread is only reported on a full window
  `WSD_ASSERT(a_spread_full, !(out_valid_q && ((out_q.spread_x != '0) ||
                               (out_q.spread_y != '0))) || out_q.window_full)

endmodule

// ===== rtl/core/wsd_cell.sv =====
// One window cell: holds an x/y sample and passes it to its neighbor on shift
`timescale 1ns / 1ps
module wsd_cell (
  input  logic             clk_i,
  input  logic             shift_i,
  input  wsd_pkg::sample_t sample_i,
  output wsd_pkg::sample_t sample_o
);

  wsd_pkg::sample_t sample_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      sample_q <= sample_i;
    end
  end

  assign sample_o = sample_q;

endmodule

// ===== rtl/core/wsd_spread.sv =====
// Running min/max of one axis as the ring rotates past it; spread = max - min
`timescale 1ns / 1ps
module wsd_spread (
  input  logic                             clk_i,
  input  wsd_pkg::scan_ctrl_t              ctrl_i,
  input  logic signed [wsd_pkg::DataW-1:0] value_i,
  output logic [wsd_pkg::DataW-1:0]        spread_o
);

  logic signed [wsd_pkg::DataW-1:0] lo_q, hi_q;
  logic signed [wsd_pkg::DataW:0]   diff;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      if (ctrl_i.init) begin
        lo_q <= value_i;
        hi_q <= value_i;
      end else begin
        if (value_i < lo_q) lo_q <= value_i;
        if (value_i > hi_q) hi_q <= value_i;
      end
    end
  end

  assign diff     = {hi_q[wsd_pkg::DataW-1], hi_q} - {lo_q[wsd_pkg::DataW-1], lo_q};
  assign spread_o = diff[wsd_pkg::DataW-1:0];

endmodule
